// ----- sv/ostt_pkg.sv -----
// Shared constants and types for the one-shot timer table.
package ostt_pkg;

   // table geometry
   localparam int SLOTS       = 32;
   localparam int MAX_RESULTS = 32;
   localparam int IDX_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int SCAN_W      = $clog2(SLOTS + 1);
   localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

   // field widths
   localparam int CMD_W     = 2;
   localparam int CHANNEL_W = 10;
   localparam int SECONDS_W = 16;
   localparam int ACTION_W  = 2;
   localparam int KIND_W    = 3;
   localparam int SLOT_W    = 5;

   // command codes
   localparam logic [CMD_W-1:0] CMD_SCHEDULE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_TICK     = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RELEASE  = 2'd2;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_SCHEDULED = 3'd0;
   localparam logic [KIND_W-1:0] KIND_FULL      = 3'd1;
   localparam logic [KIND_W-1:0] KIND_EXPIRED   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_TICK_NONE = 3'd3;
   localparam logic [KIND_W-1:0] KIND_RELEASED  = 3'd4;

   // one table entry as held in memory
   typedef struct packed {
      logic [SECONDS_W-1:0] remaining;
      logic [CHANNEL_W-1:0] owner;
      logic [ACTION_W-1:0]  action;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

endpackage

// ----- sv/ostt_if.sv -----
// Request and response channel interfaces of the one-shot timer table.
interface ostt_req_if;
   import ostt_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CMD_W-1:0]     cmd;
   logic [CHANNEL_W-1:0] channel;
   logic [SECONDS_W-1:0] seconds;
   logic [ACTION_W-1:0]  action;

   modport source (output valid, cmd, channel, seconds, action, input ready);
   modport sink   (input valid, cmd, channel, seconds, action, output ready);
endinterface

interface ostt_rsp_if;
   import ostt_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [KIND_W-1:0]    kind;
   logic [SLOT_W-1:0]    slot;
   logic [CHANNEL_W-1:0] owner;
   logic [ACTION_W-1:0]  fired_action;
   logic                 last;

   modport source (output valid, kind, slot, owner, fired_action, last, input ready);
   modport sink   (input valid, kind, slot, owner, fired_action, last, output ready);
endinterface

// ----- sv/one_shot_timer_table.sv -----
// Top level of the one-shot timer table: scan sequencer around one entry RAM.
//
//   channel   dir   beat contents
//   req_bus   in    cmd, channel, seconds, action
//   rsp_bus   out   kind, slot, owner, fired_action, last
//
// Each item walks the slot RAM once, one slot per cycle unless rsp_bus stalls, read then
// write back. Tick and release visit every slot; schedule stops at the first free slot.
// The registered RAM read lies between issuing a slot's read and processing that slot.
// Reset is synchronous; per-slot valid bits make every slot read as zero after reset.
// A stalled rsp_bus holds the scan on the slot that needs to emit.
// cmd 3 is accepted and produces nothing.
module one_shot_timer_table (
   input  logic      clock,
   input  logic      reset,
   ostt_req_if.sink   req_bus,
   ostt_rsp_if.source rsp_bus
);
   import ostt_pkg::*;

   // control state
   state_type                state_ff, state_in;
   logic                     pv_ff, pv_in;
   logic [SCAN_W-1:0]        rd_addr_ff, rd_addr_in;
   logic [IDX_W-1:0]         paddr_ff, paddr_in;
   logic [CNT_W-1:0]         n_ff, n_in;
   logic                     pend_ff, pend_in;
   logic [SLOTS-1:0]         valid_ff, valid_in;
   logic                     out_valid_ff, out_valid_in;

   // item and pending-expiry payload
   logic [CMD_W-1:0]         cmd_ff, cmd_in;
   logic [CHANNEL_W-1:0]     chan_ff, chan_in;
   logic [SECONDS_W-1:0]     secs_ff, secs_in;
   logic [ACTION_W-1:0]      act_ff, act_in;
   logic [IDX_W-1:0]         pend_slot_ff, pend_slot_in;
   logic [CHANNEL_W-1:0]     pend_owner_ff, pend_owner_in;
   logic [ACTION_W-1:0]      pend_action_ff, pend_action_in;

   // output register
   logic [KIND_W-1:0]        kind_ff, kind_in;
   logic [SLOT_W-1:0]        slot_ff, slot_in;
   logic [CHANNEL_W-1:0]     owner_ff, owner_in;
   logic [ACTION_W-1:0]      fact_ff, fact_in;
   logic                     last_ff, last_in;

   // datapath
   logic                     accept;
   logic                     out_free;
   logic [ENTRY_W-1:0]       ram_q;
   entry_type                cur;
   entry_type                wr_entry;
   logic                     wr_en;
   logic                     rd_en;
   logic [SECONDS_W-1:0]     dec_rem;
   logic                     is_sched, is_tick, is_release;
   logic                     hit, fire, last_slot;
   logic                     need_out, proc_ok, proc, advance, issue;
   logic                     out_load;

   assign accept   = req_bus.valid && req_bus.ready;
   assign out_free = !out_valid_ff || rsp_bus.ready;

   assign is_sched   = (cmd_ff == CMD_SCHEDULE);
   assign is_tick    = (cmd_ff == CMD_TICK);
   assign is_release = (cmd_ff == CMD_RELEASE);

   // entry being processed; never-written slots read as zero
   assign cur       = valid_ff[paddr_ff] ? entry_type'(ram_q) : '0;
   assign dec_rem   = (cur.remaining != '0) ? cur.remaining - 1'b1 : cur.remaining;
   assign hit       = (cur.remaining == '0);
   assign fire      = (dec_rem == '0) && (cur.action != '0) &&
                      (n_ff < CNT_W'(MAX_RESULTS));
   assign last_slot = (paddr_ff == IDX_W'(SLOTS - 1));

   // does this slot have to push a result now
   always_comb begin
      need_out = 1'b0;
      if (is_sched) begin
         need_out = hit || last_slot;
      end else if (is_tick) begin
         need_out = fire && pend_ff;
      end
   end

   assign proc_ok = !need_out || out_free;
   assign proc    = (state_ff == ST_SCAN) && pv_ff && proc_ok;
   assign advance = !pv_ff || proc_ok;
   assign issue   = (state_ff == ST_SCAN) && advance && (rd_addr_ff < SCAN_W'(SLOTS));
   assign rd_en   = issue;

   // write-back of the processed slot
   always_comb begin
      wr_en    = 1'b0;
      wr_entry = cur;
      if (proc) begin
         if (is_sched) begin
            if (hit) begin
               wr_en    = 1'b1;
               wr_entry = '{remaining: secs_ff, owner: chan_ff, action: act_ff};
            end
         end else if (is_tick) begin
            wr_en = 1'b1;
            if (fire) begin
               wr_entry = '0;
            end else begin
               wr_entry.remaining = dec_rem;
            end
         end else if (is_release) begin
            if (cur.owner == chan_ff) begin
               wr_en    = 1'b1;
               wr_entry = '0;
            end
         end
      end
   end

   ostt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOTS)
   ) u_entries (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (paddr_ff),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr_ff[IDX_W-1:0]),
      .rd_data (ram_q)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_bus.cmd == CMD_SCHEDULE || req_bus.cmd == CMD_TICK ||
                           req_bus.cmd == CMD_RELEASE)) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (proc && is_sched && (hit || last_slot)) begin
               state_in = ST_IDLE;
            end else if (proc && last_slot) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer and datapath register updates
   always_comb begin
      cmd_in         = cmd_ff;
      chan_in        = chan_ff;
      secs_in        = secs_ff;
      act_in         = act_ff;
      rd_addr_in     = rd_addr_ff;
      paddr_in       = paddr_ff;
      pv_in          = 1'b0;
      n_in           = n_ff;
      pend_in        = pend_ff;
      pend_slot_in   = pend_slot_ff;
      pend_owner_in  = pend_owner_ff;
      pend_action_in = pend_action_ff;
      valid_in       = valid_ff;
      out_load       = 1'b0;
      kind_in        = kind_ff;
      slot_in        = slot_ff;
      owner_in       = owner_ff;
      fact_in        = fact_ff;
      last_in        = last_ff;

      // latch the item and restart the scan
      if (accept) begin
         cmd_in     = req_bus.cmd;
         chan_in    = req_bus.channel;
         secs_in    = req_bus.seconds;
         act_in     = req_bus.action;
         rd_addr_in = '0;
         n_in       = '0;
         pend_in    = 1'b0;
      end

      // read side of the scan
      if (state_ff == ST_SCAN) begin
         pv_in = advance ? issue : pv_ff;
         if (issue) begin
            rd_addr_in = rd_addr_ff + 1'b1;
            paddr_in   = rd_addr_ff[IDX_W-1:0];
         end
      end

      if (wr_en) begin
         valid_in[paddr_ff] = 1'b1;
      end

      // results produced while scanning
      if (proc && need_out) begin
         out_load = 1'b1;
         if (is_sched && hit) begin
            kind_in  = KIND_SCHEDULED;
            slot_in  = SLOT_W'(paddr_ff);
            owner_in = chan_ff;
            fact_in  = act_ff;
            last_in  = 1'b1;
         end else if (is_sched) begin
            kind_in  = KIND_FULL;
            slot_in  = '0;
            owner_in = '0;
            fact_in  = '0;
            last_in  = 1'b1;
         end else begin
            kind_in  = KIND_EXPIRED;
            slot_in  = SLOT_W'(pend_slot_ff);
            owner_in = pend_owner_ff;
            fact_in  = pend_action_ff;
            last_in  = 1'b0;
         end
      end

      // hold the newest expiry back until we know whether it is the last
      if (proc && is_tick && fire) begin
         pend_in        = 1'b1;
         pend_slot_in   = paddr_ff;
         pend_owner_in  = cur.owner;
         pend_action_in = cur.action;
         n_in           = n_ff + 1'b1;
      end

      // closing result of a tick or release
      if (state_ff == ST_DONE && out_free) begin
         out_load = 1'b1;
         last_in  = 1'b1;
         if (is_tick && pend_ff) begin
            kind_in  = KIND_EXPIRED;
            slot_in  = SLOT_W'(pend_slot_ff);
            owner_in = pend_owner_ff;
            fact_in  = pend_action_ff;
         end else begin
            kind_in  = is_tick ? KIND_TICK_NONE : KIND_RELEASED;
            slot_in  = '0;
            owner_in = '0;
            fact_in  = '0;
         end
      end

      out_valid_in = out_load || (out_valid_ff && !rsp_bus.ready);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pv_ff        <= 1'b0;
         rd_addr_ff   <= '0;
         n_ff         <= '0;
         pend_ff      <= 1'b0;
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pv_ff        <= pv_in;
         rd_addr_ff   <= rd_addr_in;
         n_ff         <= n_in;
         pend_ff      <= pend_in;
         valid_ff     <= valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      chan_ff        <= chan_in;
      secs_ff        <= secs_in;
      act_ff         <= act_in;
      paddr_ff       <= paddr_in;
      pend_slot_ff   <= pend_slot_in;
      pend_owner_ff  <= pend_owner_in;
      pend_action_ff <= pend_action_in;
      kind_ff        <= kind_in;
      slot_ff        <= slot_in;
      owner_ff       <= owner_in;
      fact_ff        <= fact_in;
      last_ff        <= last_in;
   end

   // ports
   assign req_bus.ready        = (state_ff == ST_IDLE);
   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.kind         = kind_ff;
   assign rsp_bus.slot         = slot_ff;
   assign rsp_bus.owner        = owner_ff;
   assign rsp_bus.fired_action = fact_ff;
   assign rsp_bus.last         = last_ff;

endmodule

// ----- sv/ostt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ostt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, data holds while rd_en is low
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

// ----- sim/timer_table_checker.sv -----
`timescale 1ns / 100ps
// Result checker for the one-shot timer table: predicts every response beat and compares.
module timer_table_checker (
   input  logic clock,
   input  logic reset,
   ostt_req_if  req_bus,
   ostt_rsp_if  rsp_bus,
   output int   mismatches,
   output int   outstanding
);
   import ostt_pkg::*;

   typedef struct packed {
      logic [KIND_W-1:0]    kind;
      logic [SLOT_W-1:0]    slot;
      logic [CHANNEL_W-1:0] owner;
      logic [ACTION_W-1:0]  fired_action;
      logic                 last;
   } timer_beat_type;

   // keep the log short when things go badly wrong
   localparam int REPORT_LIMIT = 40;

   // shadow copy of the timer table
   logic [SECONDS_W-1:0] ticks_left  [SLOTS];
   logic [CHANNEL_W-1:0] slot_owner  [SLOTS];
   logic [ACTION_W-1:0]  slot_action [SLOTS];

   // response beats still owed by the block, oldest first
   timer_beat_type due_beats [$];

   initial begin
      mismatches  = 0;
      outstanding = 0;
   end

   function automatic timer_beat_type make_beat(input logic [KIND_W-1:0] kind,
                                                input logic [SLOT_W-1:0] slot,
                                                input logic [CHANNEL_W-1:0] owner,
                                                input logic [ACTION_W-1:0] act,
                                                input logic last);
      timer_beat_type beat;
      beat.kind         = kind;
      beat.slot         = slot;
      beat.owner        = owner;
      beat.fired_action = act;
      beat.last         = last;
      return beat;
   endfunction

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
         $display("%0t ns: %s", $time, what);
      end
   endtask

   task automatic clear_slot(input int i);
      ticks_left[i]  = '0;
      slot_owner[i]  = '0;
      slot_action[i] = '0;
   endtask

   // advance the shadow table by one request and queue the beats it causes
   task automatic predict_item(input logic [CMD_W-1:0] cmd,
                               input logic [CHANNEL_W-1:0] ch,
                               input logic [SECONDS_W-1:0] secs,
                               input logic [ACTION_W-1:0] act);
      timer_beat_type tail;
      int fired;
      bit placed;
      fired  = 0;
      placed = 1'b0;
      case (cmd)
         CMD_SCHEDULE: begin
            // lowest slot with a zero count takes the timer
            for (int i = 0; i < SLOTS; i++) begin
               if (!placed && ticks_left[i] == '0) begin
                  ticks_left[i]  = secs;
                  slot_owner[i]  = ch;
                  slot_action[i] = act;
                  due_beats.push_back(make_beat(KIND_SCHEDULED, SLOT_W'(i), ch, act, 1'b1));
                  placed = 1'b1;
               end
            end
            if (!placed) begin
               due_beats.push_back(make_beat(KIND_FULL, '0, '0, '0, 1'b1));
            end
         end
         CMD_TICK: begin
            // count down, then fire and clear zero-count slots holding an action
            for (int i = 0; i < SLOTS; i++) begin
               if (ticks_left[i] != '0) begin
                  ticks_left[i] = ticks_left[i] - 1'b1;
               end
               if (ticks_left[i] == '0 && slot_action[i] != '0 && fired < MAX_RESULTS) begin
                  due_beats.push_back(make_beat(KIND_EXPIRED, SLOT_W'(i), slot_owner[i],
                                                slot_action[i], 1'b0));
                  fired++;
                  clear_slot(i);
               end
            end
            if (fired == 0) begin
               due_beats.push_back(make_beat(KIND_TICK_NONE, '0, '0, '0, 1'b1));
            end else begin
               tail      = due_beats.pop_back();
               tail.last = 1'b1;
               due_beats.push_back(tail);
            end
         end
         CMD_RELEASE: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (slot_owner[i] == ch) begin
                  clear_slot(i);
               end
            end
            due_beats.push_back(make_beat(KIND_RELEASED, '0, '0, '0, 1'b1));
         end
         default: begin
            // undefined command: no beat, table untouched
         end
      endcase
   endtask

   // compare one response beat against the oldest prediction
   task automatic check_beat();
      timer_beat_type want;
      if (due_beats.size() == 0) begin
         report_mismatch($sformatf("unexpected beat: kind %0d slot %0d owner %0d",
                                   rsp_bus.kind, rsp_bus.slot, rsp_bus.owner));
      end else begin
         want = due_beats.pop_front();
         if (rsp_bus.kind !== want.kind) begin
            report_mismatch($sformatf("kind %0d, expected %0d", rsp_bus.kind, want.kind));
         end
         if (rsp_bus.slot !== want.slot) begin
            report_mismatch($sformatf("slot %0d, expected %0d (kind %0d)",
                                      rsp_bus.slot, want.slot, want.kind));
         end
         if (rsp_bus.owner !== want.owner) begin
            report_mismatch($sformatf("owner %0d, expected %0d (kind %0d slot %0d)",
                                      rsp_bus.owner, want.owner, want.kind, want.slot));
         end
         if (rsp_bus.fired_action !== want.fired_action) begin
            report_mismatch($sformatf("action %0d, expected %0d (kind %0d slot %0d)",
                                      rsp_bus.fired_action, want.fired_action,
                                      want.kind, want.slot));
         end
         if (rsp_bus.last !== want.last) begin
            report_mismatch($sformatf("last %0b, expected %0b (kind %0d slot %0d)",
                                      rsp_bus.last, want.last, want.kind, want.slot));
         end
      end
   endtask

   // watch both channels at the clock edge
   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            clear_slot(i);
         end
         due_beats.delete();
      end else begin
         // response beat first: it always belongs to an earlier request
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            check_beat();
         end
         if (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) begin
            predict_item(req_bus.cmd, req_bus.channel, req_bus.seconds, req_bus.action);
         end
      end
      outstanding = due_beats.size();
   end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// Testbench top for the one-shot timer table: clock, reset, stimulus, stalls and verdict.
module tb_top;
   import ostt_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNDEFINED = 2'd3;

   localparam int RANDOM_ITEMS = 200;
   localparam int QUIET_LIMIT  = 4000;
   localparam int LONG_HOLD    = 400;
   localparam int DRAIN_CYCLES = 60;

   typedef enum logic [1:0] {
      RX_FREE,
      RX_RANDOM,
      RX_PATTERN,
      RX_SPARSE
   } rx_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   int mismatches;
   int outstanding;
   int items_sent;
   int burst_left;
   int quiet_cycles;
   bit long_hold_wanted;

   ostt_req_if req_bus ();
   ostt_rsp_if rsp_bus ();

   one_shot_timer_table dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   timer_table_checker table_monitor (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always #5 clock = ~clock;

   // offer one request beat, hold it until taken, then maybe leave a gap
   task automatic send_item(input logic [CMD_W-1:0] cmd,
                            input logic [CHANNEL_W-1:0] ch,
                            input logic [SECONDS_W-1:0] secs,
                            input logic [ACTION_W-1:0] act);
      @(negedge clock);
      req_bus.valid   <= 1'b1;
      req_bus.cmd     <= cmd;
      req_bus.channel <= ch;
      req_bus.seconds <= secs;
      req_bus.action  <= act;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      if (cmd != CMD_UNDEFINED) begin
         items_sent++;
      end
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(0, 5)) @(negedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(0, 6);
      end
   endtask

   // stop offering and wait until every predicted beat has come back
   task automatic pause_until_drained();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      burst_left = 0;
      wait (outstanding == 0);
   endtask

   // response side: its own stall pattern, plus one long hold-off when asked
   initial begin : rsp_stall
      rx_mode_type mode;
      int span_left;
      int hold_left;
      int rx_cycle;
      mode      = RX_FREE;
      span_left = 0;
      hold_left = 0;
      rx_cycle  = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rx_cycle++;
         if (long_hold_wanted) begin
            long_hold_wanted = 1'b0;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            if (span_left == 0) begin
               mode      = rx_mode_type'($urandom_range(0, 3));
               span_left = $urandom_range(10, 80);
            end
            span_left--;
            case (mode)
               RX_FREE:    rsp_bus.ready <= 1'b1;
               RX_RANDOM:  rsp_bus.ready <= ($urandom_range(0, 99) < 70);
               RX_PATTERN: rsp_bus.ready <= (rx_cycle % 4 != 3);
               default:    rsp_bus.ready <= ($urandom_range(0, 99) < 20);
            endcase
         end
      end
   end

   // watchdog: too long without any beat on either channel
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // stimulus
   initial begin : stimulus
      int phase_no;
      int first_random;
      int roll;
      bit wide;
      logic [CHANNEL_W-1:0] ch;
      logic [SECONDS_W-1:0] secs;
      req_bus.valid   = 1'b0;
      req_bus.cmd     = CMD_TICK;
      req_bus.channel = '0;
      req_bus.seconds = '0;
      req_bus.action  = '0;
      long_hold_wanted = 1'b0;
      burst_left = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty table, zero count, zero action, overwrite of a free slot
      send_item(CMD_TICK, '0, '0, '0);
      send_item(CMD_RELEASE, '0, '0, '0);
      send_item(CMD_SCHEDULE, 10'd1023, 16'd0, 2'd3);
      send_item(CMD_TICK, '0, '0, '0);
      send_item(CMD_SCHEDULE, 10'd1023, 16'd0, 2'd3);
      send_item(CMD_SCHEDULE, 10'd0, 16'd2, 2'd0);
      send_item(CMD_SCHEDULE, 10'd512, 16'hFFFF, 2'd2);
      send_item(CMD_SCHEDULE, 10'd1, 16'd1, 2'd1);
      send_item(CMD_SCHEDULE, 10'd2, 16'd1, 2'd2);
      send_item(CMD_TICK, 10'd1023, 16'hFFFF, 2'd3);
      send_item(CMD_TICK, '0, '0, '0);
      send_item(CMD_SCHEDULE, 10'd3, 16'd3, 2'd3);
      send_item(CMD_RELEASE, 10'd512, '0, '0);
      send_item(CMD_RELEASE, 10'd3, '0, '0);
      send_item(CMD_UNDEFINED, 10'd1023, 16'hFFFF, 2'd3);
      send_item(CMD_SCHEDULE, 10'h2AA, 16'hAAAA, 2'd1);
      send_item(CMD_SCHEDULE, 10'h155, 16'h5555, 2'd2);
      send_item(CMD_TICK, '0, '0, '0);
      send_item(CMD_RELEASE, 10'h2AA, '0, '0);
      send_item(CMD_RELEASE, 10'h155, '0, '0);
      send_item(CMD_TICK, '0, '0, '0);
      pause_until_drained();

      // random phases of well-formed sequences and noise
      first_random = items_sent;
      phase_no = 0;
      while (items_sent - first_random < RANDOM_ITEMS) begin
         if (phase_no == 3) begin
            // response side holds off while requests keep coming
            long_hold_wanted = 1'b1;
            burst_left = 1000;
            repeat (8) begin
               send_item(CMD_SCHEDULE, CHANNEL_W'($urandom_range(0, 3)), 16'd1,
                         ACTION_W'($urandom_range(1, 3)));
            end
            repeat (12) begin
               send_item(CMD_TICK, CHANNEL_W'($urandom), SECONDS_W'($urandom),
                         ACTION_W'($urandom));
            end
            pause_until_drained();
         end else if (phase_no == 0 || $urandom_range(0, 9) == 0) begin
            // overfill with short timers, then tick them out in bulk
            repeat (SLOTS + 2) begin
               send_item(CMD_SCHEDULE, CHANNEL_W'($urandom_range(0, 3)),
                         SECONDS_W'($urandom_range(1, 3)), ACTION_W'($urandom_range(1, 3)));
            end
            repeat (4) begin
               send_item(CMD_TICK, CHANNEL_W'($urandom), SECONDS_W'($urandom),
                         ACTION_W'($urandom));
            end
         end else if ($urandom_range(0, 5) == 0) begin
            // sweep the common owners so long timers do not pile up
            for (int c = 0; c < 4; c++) begin
               send_item(CMD_RELEASE, CHANNEL_W'(c), SECONDS_W'($urandom), ACTION_W'($urandom));
            end
            send_item(CMD_RELEASE, CHANNEL_W'($urandom), SECONDS_W'($urandom),
                      ACTION_W'($urandom));
         end else begin
            // mixed traffic
            repeat ($urandom_range(8, 16)) begin
               roll = $urandom_range(0, 99);
               if (roll < 50) begin
                  wide = ($urandom_range(0, 3) == 0);
                  secs = wide ? SECONDS_W'($urandom) : SECONDS_W'($urandom_range(0, 4));
                  if (wide || $urandom_range(0, 1) == 0) begin
                     ch = CHANNEL_W'($urandom_range(0, 3));
                  end else begin
                     ch = CHANNEL_W'($urandom);
                  end
                  send_item(CMD_SCHEDULE, ch, secs, ACTION_W'($urandom));
               end else if (roll < 85) begin
                  send_item(CMD_TICK, CHANNEL_W'($urandom), SECONDS_W'($urandom),
                            ACTION_W'($urandom));
               end else if (roll < 95) begin
                  ch = ($urandom_range(0, 1) == 0) ? CHANNEL_W'($urandom_range(0, 3))
                                                   : CHANNEL_W'($urandom);
                  send_item(CMD_RELEASE, ch, SECONDS_W'($urandom), ACTION_W'($urandom));
               end else begin
                  send_item(CMD_UNDEFINED, CHANNEL_W'($urandom), SECONDS_W'($urandom),
                            ACTION_W'($urandom));
               end
            end
         end
         if ($urandom_range(0, 3) == 0) begin
            pause_until_drained();
         end
         phase_no++;
      end

      // drain and give the verdict
      pause_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
